// ----- rtl/core/icps_pkg.sv -----
// ----------------------------------------------------------------------------
// icps_pkg
// Shared types, constants and the round-robin pick function of the crossbar
// scheduler.
// ----------------------------------------------------------------------------
package icps_pkg;

    localparam int PORTS       = 8;
    localparam int PRIORITIES  = 4;
    localparam int COUNT_WIDTH = 8;
    localparam int PORT_W      = 3;
    localparam int PRIO_W      = 2;
    localparam int ROW_W       = PRIO_W + PORT_W;
    localparam int ROWS        = PRIORITIES * PORTS;
    localparam int ROW_BITS    = PORTS * COUNT_WIDTH;
    localparam int USE_W       = 4;
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = 7;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_ITERATIONS = 2'd0;
    localparam logic [1:0] CFG_SPEEDUP    = 2'd1;
    localparam logic [1:0] CFG_ISLIP_MODE = 2'd2;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_SCHED = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              kind;
        logic [PORT_W-1:0] in_port;
        logic [PORT_W-1:0] out_port;
        logic [PRIO_W-1:0] prio;
    } work_t;

    typedef struct packed {
        logic              match_valid;
        logic [PORT_W-1:0] match_in;
        logic [PORT_W-1:0] match_out;
        logic [PRIO_W-1:0] match_prio;
        logic              last;
    } result_t;

    // first set bit at or after start, searching cyclically; returns {found, index}
    function automatic logic [PORT_W:0] rr_pick(logic [PORTS-1:0] r, logic [PORT_W-1:0] start);
        logic              found;
        logic [PORT_W-1:0] idx;
        logic [PORT_W-1:0] c;
        found = 1'b0;
        idx   = '0;
        for (int s = 0; s < PORTS; s++) begin
            c = start + PORT_W'(s);
            if (!found && r[c]) begin
                found = 1'b1;
                idx   = c;
            end
        end
        return {found, idx};
    endfunction

endpackage

// ----- rtl/core/icps_ram.sv -----
// ----------------------------------------------------------------------------
// icps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module icps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/icps_front.sv -----
// ----------------------------------------------------------------------------
// icps_front
// Accepts commands, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module icps_front #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [icps_pkg::PORT_W-1:0]   s_in_port,
    input  logic [icps_pkg::PORT_W-1:0]   s_out_port,
    input  logic [2:0]                    s_prio,
    output logic                          q_valid,
    output icps_pkg::work_t               q_item,
    input  logic                          q_pop
);
    import icps_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    work_t           fifo_reg [FIFO_DEPTH];
    logic [AW-1:0]   wptr_reg;
    logic [AW-1:0]   rptr_reg;
    logic [CW-1:0]   count_reg;
    work_t           item;
    logic            push;
    logic            pop;

    // an enqueue to a priority that does not exist does nothing
    always_comb begin
        item.in_port  = s_in_port;
        item.out_port = s_out_port;
        item.prio     = s_prio[PRIO_W-1:0];
        case (s_cmd)
            CMD_ENQ:   item.kind = (32'(s_prio) < PRIORITIES) ? CMD_ENQ : CMD_NOP;
            CMD_SCHED: item.kind = CMD_SCHED;
            CMD_CLEAR: item.kind = CMD_CLEAR;
            default:   item.kind = CMD_NOP;
        endcase
    end

    assign s_ready = (count_reg != CW'(FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = fifo_reg[rptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                fifo_reg[wptr_reg] <= item;
                wptr_reg <= (wptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/icps_back.sv -----
// ----------------------------------------------------------------------------
// icps_back
// Executes queued commands: count updates in RAM, and the request, grant and
// accept rounds of a schedule over a shadow copy of one priority's counts.
// ----------------------------------------------------------------------------
module icps_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  icps_pkg::work_t       q_item,
    output logic                  q_pop,
    input  logic [3:0]            iterations,
    input  logic [3:0]            speedup,
    input  logic                  islip_mode,
    output logic                  m_valid,
    input  logic                  m_ready,
    output icps_pkg::result_t     m_res
);
    import icps_pkg::*;

    localparam int LD_W = $clog2(PORTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENQ_WR,
        ST_DONE,
        ST_LOAD,
        ST_GRANT,
        ST_ACCEPT,
        ST_EMIT,
        ST_NEXT,
        ST_FLUSH
    } state_t;

    state_t                  state_reg;
    work_t                   item_reg;
    logic [ROWS-1:0]         row_valid_reg;
    logic [COUNT_WIDTH-1:0]  shadow_reg   [PORTS][PORTS];
    logic [PORT_W-1:0]       gp_store_reg [PRIORITIES][PORTS];
    logic [PORT_W-1:0]       ap_store_reg [PRIORITIES][PORTS];
    logic [PORT_W-1:0]       gp_reg       [PORTS];
    logic [PORT_W-1:0]       ap_reg       [PORTS];
    logic [USE_W-1:0]        in_used_reg  [PORTS];
    logic [USE_W-1:0]        out_used_reg [PORTS];
    logic [PORTS-1:0]        gnt_reg      [PORTS];  // per output, bit per input
    logic [PORTS-1:0]        acc_reg      [PORTS];  // per input, bit per output
    logic [PRIO_W-1:0]       p_reg;
    logic [3:0]              it_reg;
    logic [LD_W-1:0]         ld_reg;
    logic                    pend_reg;
    logic [PORT_W-1:0]       pend_row_reg;
    result_t                 held_reg;
    logic                    held_valid_reg;
    logic [RES_CNT_W-1:0]    cnt_reg;
    logic                    m_valid_reg;
    result_t                 m_res_reg;

    logic                    out_free;
    logic [ROW_W-1:0]        raddr;
    logic [ROW_W-1:0]        waddr;
    logic [ROW_BITS-1:0]     rdata;
    logic [ROW_BITS-1:0]     wdata;
    logic                    ram_we;
    logic [ROW_BITS-1:0]     cur_row;
    logic [COUNT_WIDTH-1:0]  cur_cnt;
    logic [PORTS-1:0]        req_col  [PORTS];
    logic [PORT_W:0]         gnt_pick [PORTS];
    logic [PORTS-1:0]        gnt_row  [PORTS];
    logic [PORT_W:0]         acc_pick [PORTS];
    logic                    emit_found;
    logic [PORT_W-1:0]       emit_in;
    logic [PORT_W-1:0]       emit_out;
    result_t                 new_res;
    result_t                 empty_res;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign m_valid  = m_valid_reg;
    assign m_res    = m_res_reg;

    assign raddr  = (state_reg == ST_IDLE) ? {q_item.prio, q_item.in_port}
                                           : {p_reg, ld_reg[PORT_W-1:0]};
    assign waddr  = {item_reg.prio, item_reg.in_port};
    assign ram_we = (state_reg == ST_ENQ_WR);

    // saturating count update for an enqueue
    always_comb begin
        cur_row = row_valid_reg[waddr] ? rdata : '0;
        cur_cnt = cur_row[item_reg.out_port*COUNT_WIDTH +: COUNT_WIDTH];
        wdata   = cur_row;
        wdata[item_reg.out_port*COUNT_WIDTH +: COUNT_WIDTH] =
            (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
    end

    icps_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_counts (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // requests and output-side grant arbiters
    always_comb begin
        for (int j = 0; j < PORTS; j++) begin
            for (int i = 0; i < PORTS; i++) begin
                req_col[j][i] = (in_used_reg[i] < speedup) && (out_used_reg[j] < speedup)
                                && (shadow_reg[i][j] != '0);
            end
            gnt_pick[j] = rr_pick(req_col[j], gp_reg[j]);
        end
    end

    // input-side accept arbiters
    always_comb begin
        for (int i = 0; i < PORTS; i++) begin
            for (int j = 0; j < PORTS; j++) begin
                gnt_row[i][j] = gnt_reg[j][i];
            end
            acc_pick[i] = (in_used_reg[i] < speedup) ? rr_pick(gnt_row[i], ap_reg[i]) : '0;
        end
    end

    // next match to report, input-major then output order
    always_comb begin
        emit_found = 1'b0;
        emit_in    = '0;
        emit_out   = '0;
        for (int i = PORTS - 1; i >= 0; i--) begin
            if (acc_reg[i] != '0) begin
                emit_found = 1'b1;
                emit_in    = PORT_W'(i);
            end
        end
        for (int j = 0; j < PORTS; j++) begin
            if (acc_reg[emit_in][j]) begin
                emit_out = PORT_W'(j);
            end
        end
        new_res.match_valid = 1'b1;
        new_res.match_in    = emit_in;
        new_res.match_out   = emit_out;
        new_res.match_prio  = p_reg;
        new_res.last        = 1'b0;
        empty_res           = '0;
        empty_res.last      = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            row_valid_reg  <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            pend_reg       <= 1'b0;
            for (int p = 0; p < PRIORITIES; p++) begin
                for (int j = 0; j < PORTS; j++) begin
                    gp_store_reg[p][j] <= '0;
                    ap_store_reg[p][j] <= '0;
                end
            end
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg <= q_item;
                        case (q_item.kind)
                            CMD_ENQ:   state_reg <= ST_ENQ_WR;
                            CMD_CLEAR: begin
                                row_valid_reg <= '0;
                                state_reg     <= ST_DONE;
                            end
                            CMD_SCHED: begin
                                for (int k = 0; k < PORTS; k++) begin
                                    in_used_reg[k]  <= '0;
                                    out_used_reg[k] <= '0;
                                end
                                p_reg          <= '0;
                                ld_reg         <= '0;
                                pend_reg       <= 1'b0;
                                cnt_reg        <= '0;
                                held_valid_reg <= 1'b0;
                                state_reg      <= ST_LOAD;
                            end
                            default:   state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_ENQ_WR: begin
                    row_valid_reg[waddr] <= 1'b1;
                    state_reg            <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_res_reg   <= empty_res;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_LOAD: begin
                    gp_reg <= gp_store_reg[p_reg];
                    ap_reg <= ap_store_reg[p_reg];
                    if (ld_reg != LD_W'(PORTS)) begin
                        ld_reg       <= ld_reg + 1'b1;
                        pend_reg     <= 1'b1;
                        pend_row_reg <= ld_reg[PORT_W-1:0];
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg) begin
                        for (int j = 0; j < PORTS; j++) begin
                            shadow_reg[pend_row_reg][j] <=
                                row_valid_reg[{p_reg, pend_row_reg}]
                                ? rdata[j*COUNT_WIDTH +: COUNT_WIDTH] : '0;
                        end
                    end
                    if (pend_reg && ld_reg == LD_W'(PORTS)) begin
                        it_reg    <= '0;
                        state_reg <= (iterations == '0) ? ST_NEXT : ST_GRANT;
                    end
                end
                ST_GRANT: begin
                    for (int j = 0; j < PORTS; j++) begin
                        gnt_reg[j] <= '0;
                        if (out_used_reg[j] < speedup && gnt_pick[j][PORT_W]) begin
                            gnt_reg[j][gnt_pick[j][PORT_W-1:0]] <= 1'b1;
                            if (!islip_mode) begin
                                gp_reg[j] <= gnt_pick[j][PORT_W-1:0] + 1'b1;
                            end
                        end
                    end
                    state_reg <= ST_ACCEPT;
                end
                ST_ACCEPT: begin
                    for (int i = 0; i < PORTS; i++) begin
                        acc_reg[i] <= '0;
                        if (acc_pick[i][PORT_W]) begin
                            acc_reg[i][acc_pick[i][PORT_W-1:0]] <= 1'b1;
                            in_used_reg[i] <= in_used_reg[i] + 1'b1;
                        end
                        for (int j = 0; j < PORTS; j++) begin
                            if (acc_pick[i][PORT_W] && acc_pick[i][PORT_W-1:0] == PORT_W'(j)) begin
                                out_used_reg[j]  <= out_used_reg[j] + 1'b1;
                                shadow_reg[i][j] <= shadow_reg[i][j] - 1'b1;
                                if (!islip_mode || it_reg == '0) begin
                                    ap_reg[i] <= PORT_W'(j) + 1'b1;
                                end
                                if (islip_mode && it_reg == '0) begin
                                    gp_reg[j] <= PORT_W'(i) + 1'b1;
                                end
                            end
                        end
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!emit_found) begin
                        if (it_reg + 4'd1 == iterations) begin
                            state_reg <= ST_NEXT;
                        end else begin
                            it_reg    <= it_reg + 4'd1;
                            state_reg <= ST_GRANT;
                        end
                    end else if (cnt_reg == RES_CNT_W'(MAX_RESULTS)) begin
                        // past the report limit: drop
                        acc_reg[emit_in][emit_out] <= 1'b0;
                    end else if (!held_valid_reg || out_free) begin
                        if (held_valid_reg) begin
                            m_valid_reg <= 1'b1;
                            m_res_reg   <= held_reg;
                        end
                        held_reg       <= new_res;
                        held_valid_reg <= 1'b1;
                        cnt_reg        <= cnt_reg + 1'b1;
                        acc_reg[emit_in][emit_out] <= 1'b0;
                    end
                end
                ST_NEXT: begin
                    gp_store_reg[p_reg] <= gp_reg;
                    ap_store_reg[p_reg] <= ap_reg;
                    if (p_reg == PRIO_W'(PRIORITIES - 1)) begin
                        state_reg <= ST_FLUSH;
                    end else begin
                        p_reg     <= p_reg + 1'b1;
                        ld_reg    <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_FLUSH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (held_valid_reg) begin
                            m_res_reg      <= held_reg;
                            m_res_reg.last <= 1'b1;
                        end else begin
                            m_res_reg <= empty_res;
                        end
                        held_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/islip_priority_crossbar_scheduler.sv -----
// ----------------------------------------------------------------------------
// islip_priority_crossbar_scheduler
// iSLIP / RRM crossbar scheduler over per-priority virtual output queue counts.
// ----------------------------------------------------------------------------
// Enqueue: a read of the count row, a write-back, then one result; clear and unknown
// commands: one result. Schedule: per priority the shadow counts are loaded from RAM,
// each round runs the grant, accept and emit states with one emit per match, and the
// pointers are stored; the last result follows the last priority and comes later
// when the result side stalls. One command at a time.
// Reset (synchronous, aresetn low) clears counts, pointers and config to defaults.
// ----------------------------------------------------------------------------
module islip_priority_crossbar_scheduler #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [icps_pkg::PORT_W-1:0]   s_in_port,
    input  logic [icps_pkg::PORT_W-1:0]   s_out_port,
    input  logic [2:0]                    s_prio,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_match_valid,
    output logic [icps_pkg::PORT_W-1:0]   m_match_in,
    output logic [icps_pkg::PORT_W-1:0]   m_match_out,
    output logic [icps_pkg::PRIO_W-1:0]   m_match_prio,
    output logic                          m_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [3:0]                    cfg_data
);
    import icps_pkg::*;

    logic [3:0] iterations_reg;
    logic [3:0] speedup_reg;
    logic       islip_mode_reg;
    logic       q_valid;
    logic       q_pop;
    work_t      q_item;
    result_t    res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iterations_reg <= 4'd1;
            speedup_reg    <= 4'd1;
            islip_mode_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ITERATIONS: iterations_reg <= cfg_data;
                CFG_SPEEDUP:    speedup_reg    <= cfg_data;
                CFG_ISLIP_MODE: islip_mode_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    icps_front #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_in_port  (s_in_port),
        .s_out_port (s_out_port),
        .s_prio     (s_prio),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    icps_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .iterations (iterations_reg),
        .speedup    (speedup_reg),
        .islip_mode (islip_mode_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res      (res)
    );

    assign m_match_valid = res.match_valid;
    assign m_match_in    = res.match_in;
    assign m_match_out   = res.match_out;
    assign m_match_prio  = res.match_prio;
    assign m_last        = res.last;

endmodule

// ----- sim/icps_match_checker.sv -----
// ----------------------------------------------------------------------------
// icps_match_checker
// Watches the command, result and register channels of the crossbar
// scheduler, predicts every result item from its own copy of the queue
// counts, pointers and registers, and compares field by field.
// ----------------------------------------------------------------------------
module icps_match_checker
    import icps_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [1:0]          s_cmd,
    input  logic [PORT_W-1:0]   s_in_port,
    input  logic [PORT_W-1:0]   s_out_port,
    input  logic [2:0]          s_prio,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic                m_match_valid,
    input  logic [PORT_W-1:0]   m_match_in,
    input  logic [PORT_W-1:0]   m_match_out,
    input  logic [PRIO_W-1:0]   m_match_prio,
    input  logic                m_last,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data,
    output int                  fail_count,
    output int                  pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [COUNT_WIDTH-1:0] voq_count [PORTS][PORTS][PRIORITIES];
    logic [PORT_W-1:0]      grant_ptr [PRIORITIES][PORTS];
    logic [PORT_W-1:0]      accept_ptr [PRIORITIES][PORTS];
    logic [3:0]             rounds_reg;
    logic [3:0]             speedup_reg;
    logic                   islip_reg;
    result_t                match_queue[$];

    assign pending_count = match_queue.size();

    function automatic result_t idle_result();
        result_t r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic predict_schedule();
        logic [COUNT_WIDTH-1:0] shadow [PORTS][PORTS][PRIORITIES];
        bit                     req [PORTS][PORTS];
        bit                     gnt [PORTS][PORTS];
        bit                     acc [PORTS][PORTS];
        int                     in_use [PORTS];
        int                     out_use [PORTS];
        int                     c;
        int                     emitted;
        result_t                r;
        shadow  = voq_count;
        emitted = 0;
        foreach (in_use[k]) begin
            in_use[k]  = 0;
            out_use[k] = 0;
        end
        for (int p = 0; p < PRIORITIES; p++) begin
            for (int it = 0; it < rounds_reg; it++) begin
                for (int i = 0; i < PORTS; i++) begin
                    for (int j = 0; j < PORTS; j++) begin
                        req[i][j] = in_use[i] < speedup_reg && out_use[j] < speedup_reg
                                    && shadow[i][j][p] != 0;
                        gnt[i][j] = 0;
                        acc[i][j] = 0;
                    end
                end
                for (int j = 0; j < PORTS; j++) begin
                    if (out_use[j] >= speedup_reg) continue;
                    for (int s = 0; s < PORTS; s++) begin
                        c = (grant_ptr[p][j] + s) % PORTS;
                        if (req[c][j]) begin
                            gnt[c][j] = 1;
                            if (!islip_reg) grant_ptr[p][j] = PORT_W'(c + 1);
                            break;
                        end
                    end
                end
                for (int i = 0; i < PORTS; i++) begin
                    if (in_use[i] >= speedup_reg) continue;
                    for (int s = 0; s < PORTS; s++) begin
                        c = (accept_ptr[p][i] + s) % PORTS;
                        if (gnt[i][c]) begin
                            acc[i][c] = 1;
                            in_use[i]++;
                            out_use[c]++;
                            shadow[i][c][p]--;
                            break;
                        end
                    end
                end
                for (int i = 0; i < PORTS; i++) begin
                    for (int j = 0; j < PORTS; j++) begin
                        if (!acc[i][j]) continue;
                        if (islip_reg && it == 0) begin
                            grant_ptr[p][j]  = PORT_W'(i + 1);
                            accept_ptr[p][i] = PORT_W'(j + 1);
                        end
                        if (!islip_reg) accept_ptr[p][i] = PORT_W'(j + 1);
                        if (emitted < MAX_RESULTS) begin
                            r = '0;
                            r.match_valid = 1'b1;
                            r.match_in    = PORT_W'(i);
                            r.match_out   = PORT_W'(j);
                            r.match_prio  = PRIO_W'(p);
                            match_queue.push_back(r);
                            emitted++;
                        end
                    end
                end
            end
        end
        if (emitted == 0) match_queue.push_back(idle_result());
        else match_queue[$].last = 1'b1;
    endtask

    task automatic check_result();
        result_t want;
        if (match_queue.size() == 0) begin
            $error("result item with nothing expected");
            fail_count++;
            return;
        end
        want = match_queue.pop_front();
        if (m_match_valid !== want.match_valid) begin
            $error("match_valid: expected %0d, got %0d", want.match_valid, m_match_valid);
            fail_count++;
        end
        if (m_match_in !== want.match_in) begin
            $error("match_in: expected %0d, got %0d", want.match_in, m_match_in);
            fail_count++;
        end
        if (m_match_out !== want.match_out) begin
            $error("match_out: expected %0d, got %0d", want.match_out, m_match_out);
            fail_count++;
        end
        if (m_match_prio !== want.match_prio) begin
            $error("match_prio: expected %0d, got %0d", want.match_prio, m_match_prio);
            fail_count++;
        end
        if (m_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_last);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (voq_count[i, j, p]) voq_count[i][j][p] <= '0;
            foreach (grant_ptr[p, j]) begin
                grant_ptr[p][j]  <= '0;
                accept_ptr[p][j] <= '0;
            end
            rounds_reg  <= 4'd1;
            speedup_reg <= 4'd1;
            islip_reg   <= 1'b1;
            match_queue.delete();
            fail_count  <= 0;
        end else begin
            if (m_valid && m_ready) check_result();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ITERATIONS: rounds_reg  = cfg_data;
                    CFG_SPEEDUP:    speedup_reg = cfg_data;
                    CFG_ISLIP_MODE: islip_reg   = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (cmd_t'(s_cmd))
                    CMD_SCHED: predict_schedule();
                    CMD_ENQ: begin
                        if (s_prio < PRIORITIES &&
                            voq_count[s_in_port][s_out_port][s_prio] != COUNT_MAX)
                            voq_count[s_in_port][s_out_port][s_prio] =
                                voq_count[s_in_port][s_out_port][s_prio] + 1'b1;
                        match_queue.push_back(idle_result());
                    end
                    CMD_CLEAR: begin
                        foreach (voq_count[i, j, p]) voq_count[i][j][p] = '0;
                        match_queue.push_back(idle_result());
                    end
                    default: match_queue.push_back(idle_result());
                endcase
            end
        end
    end
endmodule

// ----- sim/tb_islip_priority_crossbar_scheduler.sv -----
// ----------------------------------------------------------------------------
// tb_islip_priority_crossbar_scheduler
// Drives enqueue, schedule, clear and unknown commands plus register writes
// into the scheduler under varied idling; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_islip_priority_crossbar_scheduler;
    import icps_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_cmd = '0;
    logic [PORT_W-1:0] s_in_port = '0;
    logic [PORT_W-1:0] s_out_port = '0;
    logic [2:0]        s_prio = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_match_valid;
    logic [PORT_W-1:0] m_match_in;
    logic [PORT_W-1:0] m_match_out;
    logic [PRIO_W-1:0] m_match_prio;
    logic              m_last;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [3:0]        cfg_data = '0;
    int                fail_count;
    int                pending_count;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                quiet_cycles = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    islip_priority_crossbar_scheduler i_dut (.*);

    icps_match_checker i_checker (.*);

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // valid stays high after the item so the next one can follow at once;
    // drop it while idling and before any wait for results
    task automatic send_item(cmd_t kind, int in_p, int out_p, int pr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= kind;
        s_in_port  <= PORT_W'(in_p);
        s_out_port <= PORT_W'(out_p);
        s_prio     <= 3'(pr);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 4'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_regs(int rounds, int spd, int mode);
        drain();
        write_reg(CFG_ITERATIONS, rounds);
        write_reg(CFG_SPEEDUP, spd);
        write_reg(CFG_ISLIP_MODE, mode);
    endtask

    // mostly enqueues among schedule, clear and unknown commands; mostly low priorities in range
    task automatic random_burst(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 70)
                send_item(CMD_ENQ, $urandom_range(7), $urandom_range(7),
                          ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(3));
            else if (r < 92) send_item(CMD_SCHED, $urandom, $urandom, $urandom);
            else if (r < 97) send_item(CMD_CLEAR, $urandom, $urandom, $urandom);
            else send_item(CMD_NOP, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, every command, ignored priority
        send_item(CMD_SCHED, 0, 0, 0);
        send_item(CMD_ENQ, 0, 0, 0);
        send_item(CMD_ENQ, 7, 7, 3);
        send_item(CMD_ENQ, 7, 0, 4);
        send_item(CMD_ENQ, 3, 5, 7);
        send_item(CMD_ENQ, 0, 7, 1);
        send_item(CMD_SCHED, 7, 7, 7);
        send_item(CMD_NOP, 5, 2, 6);
        send_item(CMD_SCHED, 0, 0, 0);
        send_item(CMD_CLEAR, 7, 7, 7);
        send_item(CMD_SCHED, 0, 0, 0);

        // many matches: more filled queues than the report limit, heavy budget
        set_regs(15, 15, 1);
        for (int k = 0; k < 72; k++)
            send_item(CMD_ENQ, k % 8, (k / 8) % 8, (k / 64) % 4);
        send_item(CMD_SCHED, 0, 0, 0);
        send_item(CMD_SCHED, 0, 0, 0);
        set_regs(0, 8, 0);
        send_item(CMD_SCHED, 0, 0, 0);
        set_regs(8, 0, 1);
        send_item(CMD_SCHED, 0, 0, 0);
        send_item(CMD_CLEAR, 0, 0, 0);

        for (int ph = 0; ph < 8; ph++) begin
            set_regs($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            random_burst(22);
            // pause until all results are back
            s_valid <= 1'b0;
            while (pending_count != 0) @(posedge aclk);
        end

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
